/* src/dcau_pkg.sv */
// Package for the double-cell arithmetic unit: operation codes and payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dcau_pkg;
   localparam int CELL_W = 16;

   typedef enum logic [2:0] {
      OP_UMUL    = 3'd0,
      OP_UDIVMOD = 3'd1,
      OP_DADD    = 3'd2,
      OP_DSUB    = 3'd3,
      OP_DNEGATE = 3'd4,
      OP_SUB     = 3'd5,
      OP_LESS    = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [CELL_W-1:0] a_low;
      logic [CELL_W-1:0] a_high;
      logic [CELL_W-1:0] b_low;
      logic [CELL_W-1:0] b_high;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] result_low;
      logic [CELL_W-1:0] result_high;
      logic              divide_error;
   } rsp_type;

   // Data handed from one cell of the row to the next.
   typedef struct packed {
      logic                valid;
      logic [2:0]          op;
      logic [2*CELL_W-1:0] acc;    // dividend/remainder shift word or product
      logic [CELL_W-1:0]   quo;    // quotient bits or multiplier
      logic [CELL_W-1:0]   dvs;    // divisor or multiplicand
      logic [2*CELL_W-1:0] simple; // result of the one-step operations
   } link_type;
endpackage
`default_nettype wire

/* src/dcau_cell.sv */
// One cell of the divide/multiply row: one restoring-divide step or one
// shift-add multiply step, registered. Depends on dcau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dcau_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire dcau_pkg::link_type link_in,
   output dcau_pkg::link_type      link_out
);
   import dcau_pkg::*;

   link_type          link_ff, link_in_c;
   logic [2*CELL_W:0] trial;
   logic [2*CELL_W-1:0] shifted;

   always_comb begin
      link_in_c = link_in;
      trial     = '0;
      shifted   = '0;
      case (op_type'(link_in.op))
         OP_UDIVMOD: begin
            // Shift the partial remainder left one bit and try the divisor.
            trial = {link_in.acc, 1'b0} - {1'b0, link_in.dvs, {CELL_W{1'b0}}};
            if (!trial[2*CELL_W]) begin
               link_in_c.acc = trial[2*CELL_W-1:0];
               link_in_c.quo = {link_in.quo[CELL_W-2:0], 1'b1};
            end else begin
               link_in_c.acc = {link_in.acc[2*CELL_W-2:0], 1'b0};
               link_in_c.quo = {link_in.quo[CELL_W-2:0], 1'b0};
            end
         end
         OP_UMUL: begin
            // Multiplier msb first: acc = 2*acc + bit * multiplicand.
            shifted = {link_in.acc[2*CELL_W-2:0], 1'b0};
            link_in_c.acc = link_in.quo[CELL_W-1]
               ? shifted + {{CELL_W{1'b0}}, link_in.dvs} : shifted;
            link_in_c.quo = {link_in.quo[CELL_W-2:0], 1'b0};
         end
         default: begin
            link_in_c = link_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else if (advance) begin
         link_ff.valid <= link_in_c.valid;
      end
      if (advance) begin
         link_ff.op     <= link_in_c.op;
         link_ff.acc    <= link_in_c.acc;
         link_ff.quo    <= link_in_c.quo;
         link_ff.dvs    <= link_in_c.dvs;
         link_ff.simple <= link_in_c.simple;
      end
   end

   assign link_out = link_ff;
endmodule
`default_nettype wire

/* src/double_cell_arithmetic_unit.sv */
// Double-cell arithmetic unit: a row of 2*CELL_W cells, one divide or multiply
// bit per cell (a multiply uses only the second half), plus an input and an output register.
// Throughput: one transfer per cycle; the whole row stalls while rsp is held.
// Reset: synchronous, clears all valid flags; data registers are not reset.
// Depends on dcau_pkg and dcau_cell.
`timescale 1ns / 1ps
`default_nettype none
module double_cell_arithmetic_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dcau_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dcau_pkg::rsp_type      rsp_data
);
   import dcau_pkg::*;

   logic                advance;
   link_type            head_in, head_ff;
   link_type            chain [0:2*CELL_W];
   link_type            mid_link;
   logic [2*CELL_W-1:0] da, db;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff;
   logic                a_less;

   // The row moves whenever the output slot is empty or being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      da = {req_data.a_high, req_data.a_low};
      db = {req_data.b_high, req_data.b_low};
      a_less = $signed(req_data.a_low) < $signed(req_data.b_low);
      head_in        = '0;
      head_in.valid  = req_valid;
      head_in.op     = req_data.op;
      head_in.dvs    = req_data.b_low;
      case (op_type'(req_data.op))
         OP_UMUL: begin
            // The multiplier is loaded halfway down the row; the first half idles at zero.
            head_in.dvs    = req_data.a_low;
            head_in.simple = {{CELL_W{1'b0}}, req_data.b_low};
         end
         OP_UDIVMOD: begin
            // The first half reduces the high cell; the low cell enters halfway.
            head_in.acc    = {{CELL_W{1'b0}}, req_data.a_high};
            head_in.simple = {{CELL_W{1'b0}}, req_data.a_low};
         end
         OP_DADD:    head_in.simple = da + db;
         OP_DSUB:    head_in.simple = da - db;
         OP_DNEGATE: head_in.simple = '0 - da;
         OP_SUB: begin
            head_in.simple = {{CELL_W{1'b0}}, req_data.a_low - req_data.b_low};
         end
         OP_LESS: begin
            head_in.simple = {{(2*CELL_W-1){1'b0}}, a_less};
         end
         default:    head_in.simple = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= head_in.valid;
      end
      if (advance) begin
         head_ff.op     <= head_in.op;
         head_ff.acc    <= head_in.acc;
         head_ff.quo    <= head_in.quo;
         head_ff.dvs    <= head_in.dvs;
         head_ff.simple <= head_in.simple;
      end
   end

   assign chain[0] = head_ff;

   always_comb begin
      mid_link = chain[CELL_W];
      case (op_type'(chain[CELL_W].op))
         OP_UMUL: begin
            mid_link.quo = chain[CELL_W].simple[CELL_W-1:0];
         end
         OP_UDIVMOD: begin
            mid_link.acc[CELL_W-1:0] = chain[CELL_W].simple[CELL_W-1:0];
         end
         default: begin
            mid_link = chain[CELL_W];
         end
      endcase
   end

   for (genvar i = 0; i < 2*CELL_W; i++) begin : g_row
      dcau_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .link_in ((i == CELL_W) ? mid_link : chain[i]),
         .link_out(chain[i+1])
      );
   end

   always_comb begin
      rsp_in = '0;
      case (op_type'(chain[2*CELL_W].op))
         OP_UMUL: begin
            rsp_in.result_low  = chain[2*CELL_W].acc[CELL_W-1:0];
            rsp_in.result_high = chain[2*CELL_W].acc[2*CELL_W-1:CELL_W];
         end
         OP_UDIVMOD: begin
            // The remainder sits in the upper half after the last step.
            if (chain[2*CELL_W].dvs == '0) begin
               rsp_in.divide_error = 1'b1;
            end else begin
               rsp_in.result_low  = chain[2*CELL_W].acc[2*CELL_W-1:CELL_W];
               rsp_in.result_high = chain[2*CELL_W].quo;
            end
         end
         default: begin
            rsp_in.result_low  = chain[2*CELL_W].simple[CELL_W-1:0];
            rsp_in.result_high = chain[2*CELL_W].simple[2*CELL_W-1:CELL_W];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[2*CELL_W].valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("row stalled with empty output");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_error |-> rsp_data.result_low == '0
      && rsp_data.result_high == '0)
      else $error("divide error with nonzero result");
endmodule
`default_nettype wire
